>>> rtl/core/rsnbp_pkg.sv
// Shared types, codes and defaults of the ring search for the next bright pixel.
`timescale 1ns / 1ps

package rsnbp_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int PIXEL_BITS_DEF = 8;

  // Signed coordinates around a center: center 0..255, image side at most 511.
  localparam int COORD_BITS = 12;
  // Ring radius and step count within one side of a ring.
  localparam int RAD_BITS   = 10;
  localparam int STEP_BITS  = 11;

  localparam logic [7:0] THRESHOLD_RST  = 8'd140;
  localparam logic [8:0] DIM_RST        = 9'd256;
  localparam logic [7:0] JUMP_LIMIT_RST = 8'd5;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_RING  = 2'd1,
    REQ_SCAN  = 2'd2,
    REQ_NONE  = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_WIDTH      = 2'd1,
    REG_HEIGHT     = 2'd2,
    REG_JUMP_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_RING = 2'd2
  } state_t;

  typedef enum logic [1:0] {
    SIDE_BOTTOM = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] pixel_value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [7:0] hit_x;
    logic [7:0] hit_y;
    logic [7:0] ring_distance;
    logic       pen_lift;
  } res_t;

endpackage

>>> rtl/core/ring_search_next_bright_pixel_top.sv
// Top level of the ring search for the next bright pixel: image memory and probe sequencer.
`timescale 1ns / 1ps

// Load the image with pixel write requests (no result), then issue raster scan or ring
// search requests; each search gives exactly one result, shown on out_res for one cycle
// under out_valid, and the receiver cannot stall it. Searches probe one position per cycle,
// including positions outside the image; only those inside are read through the read port
// of the image memory. Each probe is issued from the position registers; its pixel is read
// into the memory read register as its position moves into the check stage, where a hit is
// detected and the result registered into out_res. A search that misses reports once its
// last probe has left the check stage; a raster scan probes at most image_width *
// image_height positions. Ring r holds 8 * r positions, radius 1 first, so a ring search
// that misses with largest radius R probes 4 * R * (R + 1) positions; when no ring reaches
// the image (center 0,0 of a 1x1 image) no position is probed. busy is high while a search
// runs; the next request may be started in the cycle its predecessor's result appears. A
// hit pixel is cleared to zero in the cycle the hit is detected.
module ring_search_next_bright_pixel_top
  import rsnbp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int DH    = $clog2(MAX_HEIGHT + 1);
  localparam int CB    = COORD_BITS;

  function automatic int clamp_dim(logic [8:0] v, int maxv);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  // Configuration registers
  logic [7:0]    thr_r, thr_nxt;
  logic [DW-1:0] w_r, w_nxt;
  logic [DH-1:0] h_r, h_nxt;
  logic [7:0]    jump_r, jump_nxt;

  // Sequencer state
  state_t                state_r, state_nxt;
  logic signed [CB-1:0]  px_r, px_nxt;       // position to probe next
  logic signed [CB-1:0]  py_r, py_nxt;
  logic [RAD_BITS-1:0]   cr_r, cr_nxt;
  logic [RAD_BITS-1:0]   maxr_r, maxr_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  side_t                 side_r, side_nxt;
  logic                  iss_done_r, iss_done_nxt;

  // Check stage: the probe issued in the previous cycle
  logic                  v2_r, v2_nxt;
  logic                  in2_r, in2_nxt;
  logic signed [CB-1:0]  px2_r, px2_nxt;
  logic signed [CB-1:0]  py2_r, py2_nxt;
  logic [AW-1:0]         addr2_r, addr2_nxt;
  logic [RAD_BITS-1:0]   cr2_r, cr2_nxt;

  // Result register
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  // Image memory
  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [PIXEL_BITS-1:0] mem_wdata;

  logic                  accept, cfg_we;
  logic                  wr_inside;
  logic [AW-1:0]         wr_addr;
  logic                  issue, in_img;
  logic [AW-1:0]         probe_addr;
  logic                  hit, miss_done;
  logic                  step_last, ring_last, scan_last;
  logic [STEP_BITS-1:0]  side_len_m1;
  logic [RAD_BITS-1:0]   maxr_calc;

  assign accept = start && !busy;
  assign cfg_we = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign busy   = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_THRESHOLD:  prdata = 32'(thr_r);
      REG_WIDTH:      prdata = 32'(w_r);
      REG_HEIGHT:     prdata = 32'(h_r);
      REG_JUMP_LIMIT: prdata = 32'(jump_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    thr_nxt  = thr_r;
    w_nxt    = w_r;
    h_nxt    = h_r;
    jump_nxt = jump_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_THRESHOLD:  thr_nxt  = pwdata[7:0];
        REG_WIDTH:      w_nxt    = DW'(clamp_dim(pwdata[8:0], MAX_WIDTH));
        REG_HEIGHT:     h_nxt    = DH'(clamp_dim(pwdata[8:0], MAX_HEIGHT));
        REG_JUMP_LIMIT: jump_nxt = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Pixel write address and bounds
  assign wr_inside = (32'(in_req.pos_x) < 32'(w_r)) && (32'(in_req.pos_y) < 32'(h_r));
  assign wr_addr   = AW'(32'(in_req.pos_y) * MAX_WIDTH + 32'(in_req.pos_x));

  // Largest ring radius that can still reach the image
  always_comb begin
    int m, t;
    m = int'(in_req.pos_x);
    if (int'(in_req.pos_y) > m) m = int'(in_req.pos_y);
    t = int'(in_req.pos_x) - int'(w_r) + 1;
    if (t < 0) t = -t;
    if (t > m) m = t;
    t = int'(in_req.pos_y) - int'(h_r) + 1;
    if (t < 0) t = -t;
    if (t > m) m = t;
    maxr_calc = RAD_BITS'(m);
  end

  // Probe position checks
  assign in_img = !px_r[CB-1] && !py_r[CB-1] &&
                  (32'(px_r[CB-2:0]) < 32'(w_r)) && (32'(py_r[CB-2:0]) < 32'(h_r));
  assign probe_addr = AW'(32'(py_r[YW-1:0]) * MAX_WIDTH + 32'(px_r[XW-1:0]));
  assign issue = (state_r != ST_IDLE) && !iss_done_r;

  assign side_len_m1 = STEP_BITS'({cr_r, 1'b0}) - STEP_BITS'(1);
  assign step_last   = (step_r == side_len_m1);
  assign ring_last   = (side_r == SIDE_LEFT) && step_last && (cr_r == maxr_r);
  assign scan_last   = (32'(px_r[CB-2:0]) == 32'(w_r) - 32'd1) &&
                       (32'(py_r[CB-2:0]) == 32'(h_r) - 32'd1);

  assign hit       = v2_r && in2_r && (32'(rd_data_r) > 32'(thr_r));
  assign miss_done = iss_done_r && !v2_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_code_t'(in_req.req_type))
            REQ_RING: state_nxt = ST_RING;
            REQ_SCAN: state_nxt = ST_SCAN;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN, ST_RING: begin
        if (hit || miss_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    px_nxt        = px_r;
    py_nxt        = py_r;
    cr_nxt        = cr_r;
    maxr_nxt      = maxr_r;
    step_nxt      = step_r;
    side_nxt      = side_r;
    iss_done_nxt  = iss_done_r;
    v2_nxt        = issue;
    in2_nxt       = in_img;
    px2_nxt       = px_r;
    py2_nxt       = py_r;
    addr2_nxt     = probe_addr;
    cr2_nxt       = cr_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr;
    mem_wdata     = PIXEL_BITS'(in_req.pixel_value);
    mem_re        = issue && in_img;
    mem_raddr     = probe_addr;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cr_nxt       = RAD_BITS'(1);
          step_nxt     = '0;
          side_nxt     = SIDE_BOTTOM;
          maxr_nxt     = maxr_calc;
          iss_done_nxt = 1'b0;
          case (req_code_t'(in_req.req_type))
            REQ_WRITE: mem_we = wr_inside;
            REQ_RING: begin
              px_nxt       = CB'(in_req.pos_x);
              py_nxt       = CB'(in_req.pos_y) + CB'(1);
              iss_done_nxt = (maxr_calc == '0);
            end
            REQ_SCAN: begin
              px_nxt = '0;
              py_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue) begin
          if (scan_last) begin
            iss_done_nxt = 1'b1;
          end else if (32'(px_r[CB-2:0]) == 32'(w_r) - 32'd1) begin
            px_nxt = '0;
            py_nxt = py_r + CB'(1);
          end else begin
            px_nxt = px_r + CB'(1);
          end
        end
      end
      ST_RING: begin
        if (issue) begin
          if (ring_last) begin
            iss_done_nxt = 1'b1;
          end else if (!step_last) begin
            step_nxt = step_r + STEP_BITS'(1);
            case (side_r)
              SIDE_BOTTOM: px_nxt = px_r + CB'(1);
              SIDE_RIGHT:  py_nxt = py_r - CB'(1);
              SIDE_TOP:    px_nxt = px_r - CB'(1);
              default:     py_nxt = py_r + CB'(1);
            endcase
          end else begin
            step_nxt = '0;
            case (side_r)
              SIDE_BOTTOM: begin
                side_nxt = SIDE_RIGHT;
                py_nxt   = py_r - CB'(1);
              end
              SIDE_RIGHT: begin
                side_nxt = SIDE_TOP;
                px_nxt   = px_r - CB'(1);
              end
              SIDE_TOP: begin
                side_nxt = SIDE_LEFT;
                py_nxt   = py_r + CB'(1);
              end
              default: begin
                // advance to the next ring: its bottom side starts one row lower
                side_nxt = SIDE_BOTTOM;
                cr_nxt   = cr_r + RAD_BITS'(1);
                py_nxt   = py_r + CB'(1);
              end
            endcase
          end
        end
      end
      default: ;
    endcase

    if (busy && hit) begin
      // clear the ink pixel and drop whatever is still in flight
      mem_we        = 1'b1;
      mem_waddr     = addr2_r;
      mem_wdata     = '0;
      v2_nxt        = 1'b0;
      out_valid_nxt = 1'b1;
      out_res_nxt.found = 1'b1;
      out_res_nxt.hit_x = px2_r[7:0];
      out_res_nxt.hit_y = py2_r[7:0];
      if (state_r == ST_RING) begin
        out_res_nxt.ring_distance = (32'(cr2_r) > 32'd255) ? 8'hFF : cr2_r[7:0];
        out_res_nxt.pen_lift      = (32'(cr2_r) > 32'(jump_r));
      end else begin
        out_res_nxt.ring_distance = '0;
        out_res_nxt.pen_lift      = 1'b0;
      end
    end else if (busy && miss_done) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RST;
      w_r         <= DW'(clamp_dim(DIM_RST, MAX_WIDTH));
      h_r         <= DH'(clamp_dim(DIM_RST, MAX_HEIGHT));
      jump_r      <= JUMP_LIMIT_RST;
      state_r     <= ST_IDLE;
      iss_done_r  <= 1'b1;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      thr_r       <= thr_nxt;
      w_r         <= w_nxt;
      h_r         <= h_nxt;
      jump_r      <= jump_nxt;
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      v2_r        <= v2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    cr_r      <= cr_nxt;
    maxr_r    <= maxr_nxt;
    step_r    <= step_nxt;
    side_r    <= side_nxt;
    in2_r     <= in2_nxt;
    px2_r     <= px2_nxt;
    py2_r     <= py2_nxt;
    addr2_r   <= addr2_nxt;
    cr2_r     <= cr2_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

>>> verif/bright_pixel_checker.sv
// Request monitor, pixel-store mirror and result comparison for the bright pixel search.
`timescale 1ns / 1ps

module bright_pixel_checker
  import rsnbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  req_t        in_req,
  input  logic        out_valid,
  input  res_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending_hits
);

  logic [7:0] image_mirror [0:MAX_WIDTH_DEF*MAX_HEIGHT_DEF-1];
  logic [7:0] thr_q;
  logic [7:0] jump_q;
  int         img_w;
  int         img_h;
  res_t       expected_hits [$];

  initial begin
    fail_count   = 0;
    pending_hits = 0;
  end

  function automatic int clamp_side(logic [8:0] v, int maxv);
    if (v == 9'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

  // Test one position; clear it when it lies in the image and holds ink.
  function automatic bit take_ink(int px, int py);
    int idx;
    if (px < 0 || py < 0 || px >= img_w || py >= img_h) return 1'b0;
    idx = py * MAX_WIDTH_DEF + px;
    if (image_mirror[idx] > thr_q) begin
      image_mirror[idx] = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t scan_raster();
    res_t r;
    r = '0;
    for (int row = 0; row < img_h; row++) begin
      for (int col = 0; col < img_w; col++) begin
        if (take_ink(col, row)) begin
          r.found = 1'b1;
          r.hit_x = col[7:0];
          r.hit_y = row[7:0];
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic res_t search_rings(int cx, int cy);
    res_t r;
    int   reach;
    int   t;
    int   px;
    int   py;
    r = '0;
    reach = (cx > cy) ? cx : cy;
    t = cx - img_w + 1;
    if (t < 0) t = -t;
    if (t > reach) reach = t;
    t = cy - img_h + 1;
    if (t < 0) t = -t;
    if (t > reach) reach = t;
    for (int cr = 1; cr <= reach; cr++) begin
      for (int s = SIDE_BOTTOM; s <= SIDE_LEFT; s++) begin
        for (int k = 1 - cr; k <= cr; k++) begin
          case (side_t'(s))
            SIDE_BOTTOM: begin px = cx + k;  py = cy + cr; end
            SIDE_RIGHT:  begin px = cx + cr; py = cy - k;  end
            SIDE_TOP:    begin px = cx - k;  py = cy - cr; end
            default:     begin px = cx - cr; py = cy + k;  end
          endcase
          if (take_ink(px, py)) begin
            r.found         = 1'b1;
            r.hit_x         = px[7:0];
            r.hit_y         = py[7:0];
            r.ring_distance = (cr > 255) ? 8'd255 : cr[7:0];
            r.pen_lift      = (cr > int'(jump_q));
            return r;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s expected %0d actual %0d", fname, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    int   idx;
    if (!rst_n) begin
      thr_q  = THRESHOLD_RST;
      jump_q = JUMP_LIMIT_RST;
      img_w  = int'(DIM_RST);
      img_h  = int'(DIM_RST);
      expected_hits.delete();
    end else begin
      // Compare first: a new request may be accepted in the cycle of the previous result.
      if (out_valid) begin
        if (expected_hits.size() == 0) begin
          $error("result with no request outstanding: found %0d hit_x %0d hit_y %0d",
                 out_res.found, out_res.hit_x, out_res.hit_y);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          check_field("found", want.found, out_res.found);
          check_field("hit_x", want.hit_x, out_res.hit_x);
          check_field("hit_y", want.hit_y, out_res.hit_y);
          check_field("ring_distance", want.ring_distance, out_res.ring_distance);
          check_field("pen_lift", want.pen_lift, out_res.pen_lift);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_THRESHOLD:  thr_q  = pwdata[7:0];
          REG_WIDTH:      img_w  = clamp_side(pwdata[8:0], MAX_WIDTH_DEF);
          REG_HEIGHT:     img_h  = clamp_side(pwdata[8:0], MAX_HEIGHT_DEF);
          REG_JUMP_LIMIT: jump_q = pwdata[7:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (req_code_t'(in_req.req_type))
          REQ_WRITE: begin
            if (int'(in_req.pos_x) < img_w && int'(in_req.pos_y) < img_h) begin
              idx = int'(in_req.pos_y) * MAX_WIDTH_DEF + int'(in_req.pos_x);
              image_mirror[idx] = in_req.pixel_value;
            end
          end
          REQ_RING: expected_hits.push_back(search_rings(int'(in_req.pos_x),
                                                         int'(in_req.pos_y)));
          REQ_SCAN: expected_hits.push_back(scan_raster());
          default: ;
        endcase
      end
    end
    pending_hits = expected_hits.size();
  end

endmodule

>>> verif/tb_ring_search_next_bright_pixel_top.sv
// Stimulus, clocking and verdict for the ring search for the next bright pixel.
`timescale 1ns / 1ps

module tb_ring_search_next_bright_pixel_top;
  import rsnbp_pkg::*;

  localparam int CYCLE_LIMIT = 100_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  req_t        in_req;
  logic        out_valid;
  res_t        out_res;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          fail_count;
  int          pending_hits;
  int          cycle_count;
  int          idle_pct;
  int          cur_w;
  int          cur_h;
  logic [7:0]  cur_thr;

  ring_search_next_bright_pixel_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bright_pixel_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fail_count   (fail_count),
    .pending_hits (pending_hits)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ring_search_next_bright_pixel_top regression: fail");
      $finish;
    end
  end

  function automatic req_t mk_req(req_code_t code, int x, int y, int v);
    req_t r;
    r.req_type    = code;
    r.pos_x       = x[7:0];
    r.pos_y       = y[7:0];
    r.pixel_value = v[7:0];
    return r;
  endfunction

  function automatic int clamp_side(int v);
    if (v < 1) return 1;
    if (v > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return v;
  endfunction

  function automatic int pixel_for(bit ink);
    if (ink && cur_thr != 8'd255) return $urandom_range(255, int'(cur_thr) + 1);
    return $urandom_range(int'(cur_thr), 0);
  endfunction

  // Hold the request until accepted, then maybe leave a gap.
  task automatic send(req_t r);
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    if ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_hits != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int thr, int w_raw, int h_raw, int jl);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_WIDTH, w_raw);
    cfg_write(REG_HEIGHT, h_raw);
    cfg_write(REG_JUMP_LIMIT, jl);
    cur_thr = thr[7:0];
    cur_w   = clamp_side(w_raw);
    cur_h   = clamp_side(h_raw);
  endtask

  // Define every pixel of the current image before any search reads it.
  task automatic load_image(int ink_pct);
    for (int y = 0; y < cur_h; y++)
      for (int x = 0; x < cur_w; x++)
        send(mk_req(REQ_WRITE, x, y, pixel_for($urandom_range(99, 0) < ink_pct)));
  endtask

  task automatic run_random(int n_reqs);
    req_t r;
    int   roll;
    int   x;
    int   y;
    int   sent;
    sent = 0;
    while (sent < n_reqs) begin
      roll = $urandom_range(99, 0);
      if (roll < 45) begin
        if ($urandom_range(19, 0) == 0) begin
          x = $urandom_range(255, 0);
          y = $urandom_range(255, 0);
        end else begin
          x = $urandom_range(cur_w - 1, 0);
          y = $urandom_range(cur_h - 1, 0);
        end
        r = mk_req(REQ_WRITE, x, y, pixel_for($urandom_range(1, 0)));
        if (x < cur_w && y < cur_h) sent++;
      end else if (roll < 82) begin
        // Keep centers near the image so that ring walks stay short.
        x = $urandom_range((cur_w > 254) ? 255 : cur_w + 1, 0);
        y = $urandom_range((cur_h > 254) ? 255 : cur_h + 1, 0);
        r = mk_req(REQ_RING, x, y, $urandom_range(255, 0));
        sent++;
      end else if (roll < 95) begin
        r = mk_req(REQ_SCAN, $urandom_range(255, 0), $urandom_range(255, 0),
                   $urandom_range(255, 0));
        sent++;
      end else begin
        r = mk_req(REQ_NONE, $urandom_range(255, 0), $urandom_range(255, 0),
                   $urandom_range(255, 0));
      end
      send(r);
    end
  endtask

  task automatic run_phase(int thr, int w_raw, int h_raw, int jl, int ink_pct, int n_reqs,
                           int idle);
    idle_pct = idle;
    set_config(thr, w_raw, h_raw, jl);
    load_image(ink_pct);
    run_random(n_reqs);
    drain();
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 16x16 background without ink, then placed hits on every ring side.
    set_config(140, 16, 16, 2);
    load_image(0);
    send(mk_req(REQ_WRITE, 0, 0, 0));
    send(mk_req(REQ_WRITE, 15, 15, 140));
    send(mk_req(REQ_WRITE, 5, 5, 255));
    send(mk_req(REQ_RING, 5, 3, 0));
    send(mk_req(REQ_WRITE, 9, 5, 200));
    send(mk_req(REQ_RING, 6, 5, 0));
    send(mk_req(REQ_WRITE, 6, 1, 141));
    send(mk_req(REQ_RING, 6, 4, 0));
    send(mk_req(REQ_WRITE, 1, 8, 255));
    send(mk_req(REQ_RING, 4, 8, 0));
    // Center outside the image.
    send(mk_req(REQ_WRITE, 15, 3, 255));
    send(mk_req(REQ_RING, 20, 3, 0));
    // Writes outside the image and the unused code must leave no trace.
    send(mk_req(REQ_WRITE, 255, 255, 255));
    send(mk_req(REQ_WRITE, 16, 0, 255));
    send(mk_req(REQ_NONE, 255, 255, 255));
    send(mk_req(REQ_SCAN, 255, 255, 255));
    send(mk_req(REQ_WRITE, 12, 1, 250));
    send(mk_req(REQ_WRITE, 3, 9, 255));
    send(mk_req(REQ_SCAN, 0, 0, 0));
    send(mk_req(REQ_SCAN, 0, 0, 0));
    send(mk_req(REQ_SCAN, 0, 0, 0));
    send(mk_req(REQ_RING, 0, 0, 0));
    send(mk_req(REQ_WRITE, 0, 1, 255));
    send(mk_req(REQ_RING, 0, 0, 0));
    drain();

    run_phase(140, 8, 6, 0, 30, 90, 0);
    // Width request above range saturates to the full row.
    run_phase(0, 300, 1, 255, 50, 90, 52);
    run_phase(255, 3, 2, 5, 30, 40, 9);
    run_phase($urandom_range(200, 60), 1, 256, 7, 50, 90, 0);
    run_phase($urandom_range(255, 0), 0, 0, 0, 50, 30, 52);
    run_phase($urandom_range(200, 40), $urandom_range(12, 2), $urandom_range(12, 2),
              $urandom_range(4, 0), 35, 90, 52);
    run_phase($urandom_range(200, 40), $urandom_range(12, 2), $urandom_range(12, 2),
              $urandom_range(4, 0), 35, 90, 9);

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ring_search_next_bright_pixel_top regression: pass");
    end else begin
      $display("ring_search_next_bright_pixel_top regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rsnbp_pkg.sv
rtl/core/ring_search_next_bright_pixel_top.sv
verif/bright_pixel_checker.sv
verif/tb_ring_search_next_bright_pixel_top.sv
